/* hw/rtl/dlr_pkg.sv */
package dlr_pkg;

   // request codes
   localparam logic [1:0] REQ_DRAW  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam int X_W     = 7;   // column bits
   localparam int Y_W     = 6;   // row bits
   localparam int DATA_W  = 8;   // frame store byte
   localparam int COUNT_W = 8;   // pixels_drawn / step counter
   localparam int ADDR_W  = 14;  // wide byte address before range check

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_DIVIDE,
      ST_PLOT,
      ST_DRAIN
   } state_type;

endpackage

/* hw/rtl/dda_line_rasterizer_core.sv */
// Line rasterizer over a 1-bit frame store of 128x64 pixels, one byte per
// eight pixels, leftmost pixel in the MSB.
// Request channel: present req_* with start high; a request is taken at a
// rising edge where start is high and busy is low. req_type selects draw line,
// read byte or clear store; an unused code answers at once with zeros.
// Result channel: rsp_valid is high for exactly one cycle per request, with
// rsp_read_data and rsp_pixels_drawn. The receiver cannot stall.
// Clear zeroes one byte per cycle. Draw line runs a restoring divide, one
// quotient bit a cycle (skipped for equal endpoints), then steps through the
// points and drains the last write-back before the result.
// Drawing issues one frame store read per plotted pixel inside the store
// and writes the merged byte back in the next cycle; a byte written in the
// cycle it is re-read is forwarded. One request is worked on at a time; the
// next request can be taken at the edge that takes the result of the
// previous one. After reset the block sweeps the store to zero with busy
// high and gives no result for that sweep.
module dda_line_rasterizer_core #(
   parameter int ROW_BYTES   = 16,
   parameter int STORE_BYTES = 1024,
   parameter int FRAC_BITS   = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_type,
   input  logic [6:0] req_x_start,
   input  logic [5:0] req_y_start,
   input  logic [6:0] req_x_end,
   input  logic [5:0] req_y_end,
   input  logic       req_pixel_value,
   input  logic [9:0] req_byte_addr,
   output logic       rsp_valid,
   output logic [7:0] rsp_read_data,
   output logic [7:0] rsp_pixels_drawn
);

   localparam int MEM_AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int DW     = dlr_pkg::X_W + FRAC_BITS;
   localparam int DCW    = $clog2(DW + 1);
   localparam int PW_X   = dlr_pkg::X_W + FRAC_BITS;
   localparam int PW_Y   = dlr_pkg::Y_W + FRAC_BITS;

   // frame store
   logic [dlr_pkg::DATA_W-1:0] mem [STORE_BYTES];
   logic                       mem_we;
   logic [MEM_AW-1:0]          mem_waddr;
   logic [dlr_pkg::DATA_W-1:0] mem_wdata;
   logic                       mem_re;
   logic [MEM_AW-1:0]          mem_raddr;
   logic [dlr_pkg::DATA_W-1:0] mem_rdata_ff;

   dlr_pkg::state_type state_ff, state_in;

   logic [MEM_AW-1:0]           clr_cnt_ff, clr_cnt_in;
   logic                        clr_rsp_ff, clr_rsp_in;
   logic                        rd_in_range_ff, rd_in_range_in;
   logic [PW_X-1:0]             x_accum_ff, x_accum_in;
   logic [PW_Y-1:0]             y_accum_ff, y_accum_in;
   logic                        x_neg_ff, x_neg_in;
   logic                        y_neg_ff, y_neg_in;
   logic [dlr_pkg::COUNT_W-1:0] step_left_ff, step_left_in;
   logic [6:0]                  steps_ff, steps_in;
   logic                        pixel_ff, pixel_in;
   logic [DCW-1:0]              div_cnt_ff, div_cnt_in;
   logic [6:0]                  div_den_ff, div_den_in;
   logic [DW-1:0]               x_quo_ff, x_quo_in;
   logic [DW-1:0]               y_quo_ff, y_quo_in;
   logic [6:0]                  x_rem_ff, x_rem_in;
   logic [6:0]                  y_rem_ff, y_rem_in;

   // write-back stage
   logic                        wr_pend_ff, wr_pend_in;
   logic [MEM_AW-1:0]           wr_addr_ff, wr_addr_in;
   logic [dlr_pkg::DATA_W-1:0]  wr_mask_ff, wr_mask_in;
   logic                        fwd_valid_ff, fwd_valid_in;
   logic [MEM_AW-1:0]           fwd_addr_ff, fwd_addr_in;
   logic [dlr_pkg::DATA_W-1:0]  fwd_data_ff, fwd_data_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [dlr_pkg::DATA_W-1:0]  rsp_read_data_ff, rsp_read_data_in;
   logic [dlr_pkg::COUNT_W-1:0] rsp_pixels_drawn_ff, rsp_pixels_drawn_in;

   logic                        accept;
   logic [7:0]                  dx;
   logic [6:0]                  dy;
   logic [6:0]                  adx;
   logic [5:0]                  ady;
   logic [6:0]                  steps;
   logic [PW_X-1:0]             x_round;
   logic [PW_Y-1:0]             y_round;
   logic [dlr_pkg::X_W-1:0]     px;
   logic [dlr_pkg::Y_W-1:0]     py;
   logic [dlr_pkg::ADDR_W-1:0]  pix_addr;
   logic                        pix_in_range;
   logic [dlr_pkg::ADDR_W-1:0]  rd_addr_wide;
   logic [dlr_pkg::DATA_W-1:0]  wb_base;
   logic [dlr_pkg::DATA_W-1:0]  wb_data;
   logic [PW_X-1:0]             x_inc;
   logic [PW_Y-1:0]             y_inc;
   logic [DW+6:0]               x_div_next;
   logic [DW+6:0]               y_div_next;

   // one restoring divide step: returns {remainder, shifted quotient}
   function automatic logic [DW+6:0] div_step(input logic [6:0]    rem,
                                              input logic [DW-1:0] quo,
                                              input logic [6:0]    den);
      logic [7:0] t;
      t = {rem, quo[DW-1]};
      if (t >= {1'b0, den}) begin
         div_step = {7'(t - {1'b0, den}), quo[DW-2:0], 1'b1};
      end else begin
         div_step = {t[6:0], quo[DW-2:0], 1'b0};
      end
   endfunction

   assign accept = start && (state_ff == dlr_pkg::ST_IDLE);
   assign busy   = (state_ff != dlr_pkg::ST_IDLE);

   assign dx    = {1'b0, req_x_end} - {1'b0, req_x_start};
   assign dy    = {1'b0, req_y_end} - {1'b0, req_y_start};
   assign adx   = dx[7] ? 7'(-dx) : dx[6:0];
   assign ady   = dy[6] ? 6'(-dy) : dy[5:0];
   assign steps = (adx > {1'b0, ady}) ? adx : {1'b0, ady};

   // round half up to the nearest pixel
   assign x_round = x_accum_ff + (PW_X'(1) << (FRAC_BITS - 1));
   assign y_round = y_accum_ff + (PW_Y'(1) << (FRAC_BITS - 1));
   assign px      = x_round[PW_X-1:FRAC_BITS];
   assign py      = y_round[PW_Y-1:FRAC_BITS];
   assign pix_addr = dlr_pkg::ADDR_W'(py) * dlr_pkg::ADDR_W'(ROW_BYTES)
                   + dlr_pkg::ADDR_W'(px[6:3]);
   assign pix_in_range = pix_addr < dlr_pkg::ADDR_W'(STORE_BYTES);
   assign rd_addr_wide = dlr_pkg::ADDR_W'(req_byte_addr);

   assign x_inc = PW_X'(x_quo_ff[FRAC_BITS:0]);
   assign y_inc = PW_Y'(y_quo_ff[FRAC_BITS:0]);

   assign x_div_next = div_step(x_rem_ff, x_quo_ff, div_den_ff);
   assign y_div_next = div_step(y_rem_ff, y_quo_ff, div_den_ff);

   // merge: take the byte written last cycle if the read raced it
   assign wb_base = (fwd_valid_ff && (fwd_addr_ff == wr_addr_ff)) ? fwd_data_ff
                                                                 : mem_rdata_ff;
   assign wb_data = pixel_ff ? (wb_base | wr_mask_ff) : (wb_base & ~wr_mask_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dlr_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  dlr_pkg::REQ_DRAW:  state_in = (steps == '0) ? dlr_pkg::ST_PLOT
                                                                : dlr_pkg::ST_DIVIDE;
                  dlr_pkg::REQ_READ:  state_in = dlr_pkg::ST_READ;
                  dlr_pkg::REQ_CLEAR: state_in = dlr_pkg::ST_CLEAR;
                  default:            state_in = dlr_pkg::ST_IDLE;
               endcase
            end
         end
         dlr_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == MEM_AW'(STORE_BYTES - 1)) state_in = dlr_pkg::ST_IDLE;
         end
         dlr_pkg::ST_READ:   state_in = dlr_pkg::ST_IDLE;
         dlr_pkg::ST_DIVIDE: begin
            if (div_cnt_ff == DCW'(1)) state_in = dlr_pkg::ST_PLOT;
         end
         dlr_pkg::ST_PLOT: begin
            if (step_left_ff == '0) state_in = dlr_pkg::ST_DRAIN;
         end
         dlr_pkg::ST_DRAIN:  state_in = dlr_pkg::ST_IDLE;
         default:            state_in = dlr_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      clr_cnt_in          = clr_cnt_ff;
      clr_rsp_in          = clr_rsp_ff;
      rd_in_range_in      = rd_in_range_ff;
      x_accum_in          = x_accum_ff;
      y_accum_in          = y_accum_ff;
      x_neg_in            = x_neg_ff;
      y_neg_in            = y_neg_ff;
      step_left_in        = step_left_ff;
      steps_in            = steps_ff;
      pixel_in            = pixel_ff;
      div_cnt_in          = div_cnt_ff;
      div_den_in          = div_den_ff;
      x_quo_in            = x_quo_ff;
      y_quo_in            = y_quo_ff;
      x_rem_in            = x_rem_ff;
      y_rem_in            = y_rem_ff;
      wr_pend_in          = 1'b0;
      wr_addr_in          = wr_addr_ff;
      wr_mask_in          = wr_mask_ff;
      fwd_valid_in        = 1'b0;
      fwd_addr_in         = fwd_addr_ff;
      fwd_data_in         = fwd_data_ff;
      rsp_valid_in        = 1'b0;
      rsp_read_data_in    = '0;
      rsp_pixels_drawn_in = '0;
      mem_we              = 1'b0;
      mem_waddr           = '0;
      mem_wdata           = '0;
      mem_re              = 1'b0;
      mem_raddr           = '0;

      // write back the pixel read last cycle
      if (wr_pend_ff) begin
         mem_we       = 1'b1;
         mem_waddr    = wr_addr_ff;
         mem_wdata    = wb_data;
         fwd_valid_in = 1'b1;
         fwd_addr_in  = wr_addr_ff;
         fwd_data_in  = wb_data;
      end

      case (state_ff)
         dlr_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  dlr_pkg::REQ_DRAW: begin
                     x_accum_in   = PW_X'(req_x_start) << FRAC_BITS;
                     y_accum_in   = PW_Y'(req_y_start) << FRAC_BITS;
                     x_neg_in     = dx[7];
                     y_neg_in     = dy[6];
                     steps_in     = steps;
                     step_left_in = dlr_pkg::COUNT_W'(steps);
                     pixel_in     = req_pixel_value;
                     div_den_in   = steps;
                     div_cnt_in   = DCW'(DW);
                     x_quo_in     = DW'(adx) << FRAC_BITS;
                     y_quo_in     = DW'(ady) << FRAC_BITS;
                     x_rem_in     = '0;
                     y_rem_in     = '0;
                  end
                  dlr_pkg::REQ_READ: begin
                     rd_in_range_in = rd_addr_wide < dlr_pkg::ADDR_W'(STORE_BYTES);
                     mem_re         = 1'b1;
                     mem_raddr      = rd_addr_wide[MEM_AW-1:0];
                  end
                  dlr_pkg::REQ_CLEAR: begin
                     clr_cnt_in = '0;
                     clr_rsp_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         dlr_pkg::ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + MEM_AW'(1);
            if (clr_cnt_ff == MEM_AW'(STORE_BYTES - 1)) begin
               rsp_valid_in = clr_rsp_ff;
               clr_rsp_in   = 1'b0;
            end
         end
         dlr_pkg::ST_READ: begin
            rsp_valid_in     = 1'b1;
            rsp_read_data_in = rd_in_range_ff ? mem_rdata_ff : '0;
         end
         dlr_pkg::ST_DIVIDE: begin
            {x_rem_in, x_quo_in} = x_div_next;
            {y_rem_in, y_quo_in} = y_div_next;
            div_cnt_in           = div_cnt_ff - DCW'(1);
         end
         dlr_pkg::ST_PLOT: begin
            // read the byte under this point, merge and write it next cycle
            mem_re     = pix_in_range;
            mem_raddr  = pix_addr[MEM_AW-1:0];
            wr_pend_in = pix_in_range;
            wr_addr_in = pix_addr[MEM_AW-1:0];
            wr_mask_in = dlr_pkg::DATA_W'(8'h80) >> px[2:0];
            if (step_left_ff != '0) begin
               x_accum_in   = x_neg_ff ? (x_accum_ff - x_inc) : (x_accum_ff + x_inc);
               y_accum_in   = y_neg_ff ? (y_accum_ff - y_inc) : (y_accum_ff + y_inc);
               step_left_in = step_left_ff - dlr_pkg::COUNT_W'(1);
            end
         end
         dlr_pkg::ST_DRAIN: begin
            rsp_valid_in        = 1'b1;
            rsp_pixels_drawn_in = dlr_pkg::COUNT_W'(steps_ff) + dlr_pkg::COUNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dlr_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         wr_pend_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_left_ff <= '0;
         x_accum_ff   <= '0;
         y_accum_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         wr_pend_ff   <= wr_pend_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         step_left_ff <= step_left_in;
         x_accum_ff   <= x_accum_in;
         y_accum_ff   <= y_accum_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_in_range_ff      <= rd_in_range_in;
      x_neg_ff            <= x_neg_in;
      y_neg_ff            <= y_neg_in;
      steps_ff            <= steps_in;
      pixel_ff            <= pixel_in;
      div_cnt_ff          <= div_cnt_in;
      div_den_ff          <= div_den_in;
      x_quo_ff            <= x_quo_in;
      y_quo_ff            <= y_quo_in;
      x_rem_ff            <= x_rem_in;
      y_rem_ff            <= y_rem_in;
      wr_addr_ff          <= wr_addr_in;
      wr_mask_ff          <= wr_mask_in;
      fwd_addr_ff         <= fwd_addr_in;
      fwd_data_ff         <= fwd_data_in;
      rsp_read_data_ff    <= rsp_read_data_in;
      rsp_pixels_drawn_ff <= rsp_pixels_drawn_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_read_data_ff;
   assign rsp_pixels_drawn = rsp_pixels_drawn_ff;

endmodule
